// ===== rtl/mlfr_pkg.sv =====
// mlfr_pkg: shared types and constants for the magic/length frame receiver.
// Used by mlfr_deframe and magic_length_frame_receiver. No dependencies.
`default_nettype none

package mlfr_pkg;

  localparam int COUNT_BITS = 21;
  localparam int LEN_BITS   = 32;
  localparam int TMO_BITS   = 16;
  localparam int STALL_BITS = 17;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [31:0]           MAGIC_RST   = 32'h3331_5653;
  localparam logic [COUNT_BITS-1:0] MAX_LEN_RST = COUNT_BITS'(16384);
  localparam logic [TMO_BITS-1:0]   TMO_RST     = 16'd5000;
  localparam logic [STALL_BITS-1:0] STALL_MAX   = '1;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LEN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] EVT_PAYLOAD = 2'd0;
  localparam logic [1:0] EVT_BAD_LEN = 2'd1;
  localparam logic [1:0] EVT_STALL   = 2'd2;

  localparam logic [1:0] CLS_JSON  = 2'd0;
  localparam logic [1:0] CLS_ENC   = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  localparam logic [7:0] BYTE_BRACE = 8'h7B;
  localparam logic [7:0] BYTE_ENC   = 8'h01;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_PAY  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]          event_kind;
    logic [7:0]          payload_byte;
    logic                first_of_frame;
    logic                last_of_frame;
    logic [1:0]          frame_class;
    logic [LEN_BITS-1:0] frame_length;
  } result_t;

  function automatic logic [1:0] classify(input logic [7:0] b);
    logic [1:0] c;
    if (b == BYTE_BRACE) begin
      c = CLS_JSON;
    end else if (b == BYTE_ENC) begin
      c = CLS_ENC;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mlfr_deframe.sv =====
// mlfr_deframe: frame parser state (magic hunt, length gather, payload,
// watchdog) and the per-item result. Depends on mlfr_pkg.
`default_nettype none

module mlfr_deframe
  import mlfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  item_fire,
  input  wire logic                  item_op,
  input  wire logic [7:0]            item_byte,
  input  wire logic [31:0]           magic_word,
  input  wire logic [COUNT_BITS-1:0] max_len,
  input  wire logic [TMO_BITS-1:0]   timeout,
  output logic                       res_valid,
  output result_t                    res
);

  phase_t                  phase_r, phase_nxt;
  logic [1:0]              mm_r, mm_nxt;
  logic [1:0]              lbs_r, lbs_nxt;
  logic [LEN_BITS-1:0]     len_r, len_nxt;
  logic [COUNT_BITS-1:0]   pc_r, pc_nxt;
  logic [1:0]              cls_r, cls_nxt;
  logic [STALL_BITS-1:0]   stall_r, stall_nxt;

  logic [STALL_BITS-1:0]   stall_inc;
  logic [LEN_BITS-1:0]     len_new;
  logic [COUNT_BITS-1:0]   pc_new;
  logic [7:0]              want;
  logic                    first;
  logic                    last;
  logic [1:0]              cls_cur;

  always_comb begin
    phase_nxt = phase_r;
    mm_nxt    = mm_r;
    lbs_nxt   = lbs_r;
    len_nxt   = len_r;
    pc_nxt    = pc_r;
    cls_nxt   = cls_r;
    stall_nxt = stall_r;
    res_valid = 1'b0;
    res       = '0;

    stall_inc = (stall_r == STALL_MAX) ? stall_r : stall_r + 1'b1;
    len_new   = len_r | (LEN_BITS'(item_byte) << {lbs_r, 3'b000});
    pc_new    = pc_r + 1'b1;
    want      = magic_word[{mm_r, 3'b000} +: 8];
    first     = (pc_r == '0);
    cls_cur   = first ? classify(item_byte) : cls_r;
    last      = (LEN_BITS'(pc_new) == len_r);

    if (item_op == OP_TICK) begin
      if (phase_r != PH_HUNT) begin
        stall_nxt = stall_inc;
        if (stall_inc > STALL_BITS'(timeout)) begin
          phase_nxt        = PH_HUNT;
          mm_nxt           = '0;
          lbs_nxt          = '0;
          pc_nxt           = '0;
          stall_nxt        = '0;
          len_nxt          = '0;
          res_valid        = 1'b1;
          res.event_kind   = EVT_STALL;
          res.frame_length = len_r;
        end
      end
    end else begin
      unique case (phase_r)
        PH_LEN: begin
          len_nxt = len_new;
          lbs_nxt = lbs_r + 1'b1;
          if (lbs_r == 2'd3) begin
            if (len_new == '0 || len_new > LEN_BITS'(max_len)) begin
              phase_nxt        = PH_HUNT;
              mm_nxt           = '0;
              lbs_nxt          = '0;
              pc_nxt           = '0;
              stall_nxt        = '0;
              res_valid        = 1'b1;
              res.event_kind   = EVT_BAD_LEN;
              res.frame_length = len_new;
            end else begin
              phase_nxt = PH_PAY;
              pc_nxt    = '0;
              stall_nxt = '0;
            end
          end
        end
        PH_PAY: begin
          cls_nxt            = cls_cur;
          pc_nxt             = pc_new;
          res_valid          = 1'b1;
          res.event_kind     = EVT_PAYLOAD;
          res.payload_byte   = item_byte;
          res.first_of_frame = first;
          res.last_of_frame  = last;
          res.frame_class    = cls_cur;
          res.frame_length   = len_r;
          if (last) begin
            phase_nxt = PH_HUNT;
            mm_nxt    = '0;
            lbs_nxt   = '0;
            pc_nxt    = '0;
            stall_nxt = '0;
          end
        end
        PH_HUNT: begin
          if (item_byte == want) begin
            if (mm_r == 2'd3) begin
              phase_nxt = PH_LEN;
              mm_nxt    = '0;
              lbs_nxt   = '0;
              len_nxt   = '0;
              stall_nxt = '0;
            end else begin
              mm_nxt = mm_r + 1'b1;
            end
          end else if (item_byte == magic_word[7:0]) begin
            mm_nxt = 2'd1;
          end else begin
            mm_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      mm_r    <= '0;
      lbs_r   <= '0;
      len_r   <= '0;
      pc_r    <= '0;
      cls_r   <= '0;
      stall_r <= '0;
    end else if (item_fire) begin
      phase_r <= phase_nxt;
      mm_r    <= mm_nxt;
      lbs_r   <= lbs_nxt;
      len_r   <= len_nxt;
      pc_r    <= pc_nxt;
      cls_r   <= cls_nxt;
      stall_r <= stall_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/magic_length_frame_receiver.sv =====
// magic_length_frame_receiver: top level; input register, config registers,
// result register. Depends on mlfr_pkg and mlfr_deframe.
`default_nettype none

// Takes one byte or tick transfer per clock while out_ready does not stall the
// result register, and gives at most one result per item. An item is held in
// the input register, parsed against the frame state in a single pass, and its
// result is held in the output register, whose valid flag drives out_valid.
// in_ready depends combinationally on out_ready through the result register's
// free slot. Configuration writes take effect on the next parsed item.
module magic_length_frame_receiver
  import mlfr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_operation,
  input  wire logic [7:0]              in_rx_byte,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_event_kind,
  output logic [7:0]                   out_payload_byte,
  output logic                         out_first_of_frame,
  output logic                         out_last_of_frame,
  output logic [1:0]                   out_frame_class,
  output logic [LEN_BITS-1:0]          out_frame_length,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [31:0]             cfg_wdata
);

  logic [31:0]           magic_r;
  logic [COUNT_BITS-1:0] max_len_r;
  logic [TMO_BITS-1:0]   timeout_r;

  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic [7:0]            s1_byte_r;

  logic                  out_valid_r;
  result_t               out_r;

  logic                  advance;
  logic                  fire;
  logic                  res_valid;
  result_t               res;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MAGIC_RST;
      max_len_r <= MAX_LEN_RST;
      timeout_r <= TMO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAGIC:   magic_r   <= cfg_wdata;
        REG_MAX_LEN: max_len_r <= cfg_wdata[COUNT_BITS-1:0];
        REG_TIMEOUT: timeout_r <= cfg_wdata[TMO_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= in_operation;
      s1_byte_r <= in_rx_byte;
    end
  end

  mlfr_deframe u_deframe (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (fire),
    .item_op    (s1_op_r),
    .item_byte  (s1_byte_r),
    .magic_word (magic_r),
    .max_len    (max_len_r),
    .timeout    (timeout_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = out_r.event_kind;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_first_of_frame = out_r.first_of_frame;
  assign out_last_of_frame  = out_r.last_of_frame;
  assign out_frame_class    = out_r.frame_class;
  assign out_frame_length   = out_r.frame_length;

endmodule

`default_nettype wire
